// ===== hdl/npt_pkg.sv =====
// Shared types, constants and text helpers for the named parameter table.
package npt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int NAME_CHARS  = 15;
	localparam int NAME_BYTES  = 15;
	localparam int NAME_W      = 8 * NAME_BYTES;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;

	localparam logic [2:0] STAT_UPDATED  = 3'd0;
	localparam logic [2:0] STAT_INSERTED = 3'd1;
	localparam logic [2:0] STAT_DROPPED  = 3'd2;
	localparam logic [2:0] STAT_HIT      = 3'd3;
	localparam logic [2:0] STAT_MISS     = 3'd4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [NAME_W-1:0] key;
		logic [31:0]       value;
		logic [7:0]        ptype;
		logic [15:0]       pindex;
		logic [15:0]       total;
		logic [6:0]        max_out;
	} npt_item_t;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [31:0]       value;
		logic [7:0]        ptype;
		logic [15:0]       pindex;
	} npt_entry_t;

	// Text ends at the first zero byte or after NAME_CHARS bytes.
	function automatic logic [NAME_W-1:0] unpack_text(input logic [63:0] lo,
			input logic [55:0] hi);
		logic [NAME_W-1:0] raw;
		logic [NAME_W-1:0] res;
		logic              ended;
		logic [7:0]        b;
		raw   = {hi, lo};
		res   = '0;
		ended = 1'b0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			b = raw[8*i +: 8];
			if (i >= NAME_CHARS || b == 8'd0) begin
				ended = 1'b1;
			end
			res[8*i +: 8] = ended ? 8'd0 : b;
		end
		return res;
	endfunction

	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [NAME_W-1:0] fold_text(input logic [NAME_W-1:0] t);
		logic [NAME_W-1:0] res;
		for (int i = 0; i < NAME_BYTES; i++) begin
			res[8*i +: 8] = fold_byte(t[8*i +: 8]);
		end
		return res;
	endfunction

	// The needle is already folded; a zero needle byte marks its end.
	function automatic logic holds_text(input logic [NAME_W-1:0] hay,
			input logic [NAME_W-1:0] needle);
		logic       res;
		logic       hit;
		logic [7:0] hb;
		logic [7:0] nb;
		int         k;
		res = 1'b0;
		for (int s = 0; s < NAME_BYTES; s++) begin
			hit = 1'b1;
			for (int j = 0; j < NAME_BYTES; j++) begin
				k  = s + j;
				nb = needle[8*j +: 8];
				hb = 8'd0;
				if (k < NAME_BYTES) begin
					hb = fold_byte(hay[8*k +: 8]);
				end
				if (nb != 8'd0 && hb != nb) begin
					hit = 1'b0;
				end
			end
			res = res | hit;
		end
		return res;
	endfunction

endpackage

// ===== hdl/npt_front.sv =====
// Front end: accepts input items, normalizes the key text and queues the work.
module npt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [63:0]        name_low,
	input  logic [55:0]        name_high,
	input  logic [31:0]        value_bits,
	input  logic [7:0]         param_type,
	input  logic [15:0]        param_index,
	input  logic [15:0]        total_count,
	input  logic [63:0]        filter_low,
	input  logic [55:0]        filter_high,
	input  logic [6:0]         max_out,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output npt_pkg::npt_item_t cmd
);
	import npt_pkg::*;

	npt_item_t  item;
	npt_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	// A list searches with the folded filter, everything else keys on the name.
	always_comb begin
		item.mode    = mode;
		item.key     = (mode == MODE_LIST) ? fold_text(unpack_text(filter_low, filter_high))
		                                   : unpack_text(name_low, name_high);
		item.value   = value_bits;
		item.ptype   = param_type;
		item.pindex  = param_index;
		item.total   = total_count;
		item.max_out = max_out;
	end

	assign in_ready  = (fill_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/npt_back.sv =====
// Back end: scans the entry memory, applies updates and drives the result register.
module npt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  npt_pkg::npt_item_t cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [63:0]        out_name_low,
	output logic [55:0]        out_name_high,
	output logic [31:0]        out_value_bits,
	output logic [7:0]         out_type,
	output logic [15:0]        out_index,
	output logic [6:0]         entry_count,
	output logic [15:0]        expected_total,
	output logic               complete,
	output logic               last
);
	import npt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} npt_fsm_t;

	npt_fsm_t         fsm_q;
	npt_entry_t       mem [MAX_ENTRIES];
	logic [CNT_W-1:0] count_q;
	logic [15:0]      total_q;
	logic             complete_q;
	logic [CNT_W-1:0] addr_q;
	logic             vld_s1;
	npt_entry_t       data_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	npt_entry_t       found_data_q;
	logic [6:0]       hits_q;
	logic             pend_vld_q;
	npt_entry_t       pend_q;

	logic             out_vld_q;
	logic [2:0]       status_q;
	npt_entry_t       oent_q;
	logic [CNT_W-1:0] ocount_q;
	logic [15:0]      ototal_q;
	logic             ocomplete_q;
	logic             olast_q;

	logic             ofree;
	logic             is_list;
	logic             match_s1;
	logic             list_hit;
	logic             stall;
	logic             scan_end;
	logic             advance;
	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] wr_slot;
	npt_entry_t       new_entry;
	logic [15:0]      new_total;
	logic [CNT_W-1:0] new_count;
	logic             new_complete;
	logic             is_full;
	logic             out_ld;
	logic [2:0]       ld_status;
	npt_entry_t       ld_entry;
	logic             ld_last;
	logic             finish;

	assign ofree    = !out_vld_q || out_ready;
	assign is_list  = (cmd.mode == MODE_LIST);
	assign match_s1 = is_list ? holds_text(data_s1.name, cmd.key) : (data_s1.name == cmd.key);
	assign list_hit = vld_s1 && is_list && match_s1 && (hits_q < cmd.max_out);
	// A second hit must push the held one out, so it waits for a free result register.
	assign stall    = list_hit && pend_vld_q && !ofree;
	assign scan_end = (!vld_s1 && addr_q >= count_q) || (is_list && hits_q >= cmd.max_out);
	assign advance  = (fsm_q == ST_SCAN) && !stall && !scan_end;
	assign rd_en    = advance && (addr_q < count_q);
	assign finish   = (fsm_q == ST_DONE) && ofree;
	assign cmd_ready = finish;

	assign is_full   = (count_q >= CNT_W'(MAX_ENTRIES));
	assign new_total = (cmd.total > total_q) ? cmd.total : total_q;

	always_comb begin
		new_entry.name   = cmd.key;
		new_entry.value  = cmd.value;
		new_entry.ptype  = cmd.ptype;
		new_entry.pindex = cmd.pindex;
		wr_slot          = found_q ? slot_q : count_q[IDX_W-1:0];
		wr_en            = finish && (cmd.mode == MODE_UPDATE) && (found_q || !is_full);
		new_count        = (wr_en && !found_q) ? count_q + CNT_W'(1) : count_q;
		new_complete     = complete_q || (wr_en && new_total != 16'd0 &&
		                   {{(16-CNT_W){1'b0}}, new_count} >= new_total);

		out_ld    = 1'b0;
		ld_status = STAT_MISS;
		ld_entry  = '0;
		ld_last   = 1'b1;
		if (fsm_q == ST_SCAN && !stall && !scan_end && list_hit && pend_vld_q) begin
			out_ld    = 1'b1;
			ld_status = STAT_HIT;
			ld_entry  = pend_q;
			ld_last   = 1'b0;
		end else if (finish) begin
			out_ld = 1'b1;
			case (cmd.mode)
				MODE_UPDATE: begin
					if (found_q) begin
						ld_status = STAT_UPDATED;
						ld_entry  = new_entry;
					end else if (!is_full) begin
						ld_status = STAT_INSERTED;
						ld_entry  = new_entry;
					end else begin
						ld_status = STAT_DROPPED;
					end
				end
				MODE_FIND: begin
					if (found_q) begin
						ld_status = STAT_HIT;
						ld_entry  = found_data_q;
					end
				end
				MODE_LIST: begin
					if (pend_vld_q) begin
						ld_status = STAT_HIT;
						ld_entry  = pend_q;
					end
				end
				default: begin
					ld_status = STAT_MISS;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= mem[addr_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			mem[wr_slot] <= new_entry;
		end
		if (advance) begin
			idx_s1 <= addr_q[IDX_W-1:0];
		end
		if (vld_s1 && !is_list && match_s1 && !found_q && fsm_q == ST_SCAN) begin
			slot_q       <= idx_s1;
			found_data_q <= data_s1;
		end
		if (advance && list_hit) begin
			pend_q <= data_s1;
		end
		if (out_ld) begin
			status_q <= ld_status;
			oent_q   <= ld_entry;
			olast_q  <= ld_last;
			ocount_q <= (cmd.mode == MODE_UPDATE) ? new_count : count_q;
			ototal_q <= (cmd.mode == MODE_UPDATE) ? new_total : total_q;
			ocomplete_q <= (cmd.mode == MODE_UPDATE) ? new_complete : complete_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= ST_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			complete_q <= 1'b0;
			addr_q     <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			hits_q     <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (fsm_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						addr_q     <= '0;
						vld_s1     <= 1'b0;
						found_q    <= 1'b0;
						hits_q     <= '0;
						pend_vld_q <= 1'b0;
						fsm_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (vld_s1 && !is_list && match_s1) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						fsm_q <= ST_DONE;
					end else if (!stall) begin
						vld_s1 <= (addr_q < count_q);
						if (addr_q < count_q) begin
							addr_q <= addr_q + CNT_W'(1);
						end
						if (list_hit) begin
							hits_q     <= hits_q + 7'd1;
							pend_vld_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (finish) begin
						if (cmd.mode == MODE_UPDATE) begin
							count_q    <= new_count;
							total_q    <= new_total;
							complete_q <= new_complete;
						end
						fsm_q <= ST_IDLE;
					end
				end
				default: begin
					fsm_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_vld_q;
	assign status         = status_q;
	assign out_name_low   = oent_q.name[63:0];
	assign out_name_high  = oent_q.name[NAME_W-1:64];
	assign out_value_bits = oent_q.value;
	assign out_type       = oent_q.ptype;
	assign out_index      = oent_q.pindex;
	assign entry_count    = 7'(ocount_q);
	assign expected_total = ototal_q;
	assign complete       = ocomplete_q;
	assign last           = olast_q;

endmodule

// ===== hdl/named_parameter_table.sv =====
// Named parameter table: a table of up to 64 entries keyed by a name of up to 15 bytes.
// Input channel (in_valid/in_ready) takes one request per transfer: mode 0 updates or
// appends an entry, mode 1 finds an entry by exact name, mode 2 lists entries whose
// name holds the filter text, ignoring ASCII case. Output channel (out_valid/out_ready)
// returns one result per transfer; last marks the final result of a request.
// Update and find give one result; a list gives one result per matching entry up to
// max_out, or a single miss. Every result carries the entry count, the largest
// announced total and the complete flag as they stand after the request.
// A small front queue holds up to two requests while the back end works.
// The back end reads the entry memory one entry per cycle while its scan is not
// stalled; a list stops early once max_out hits are found. Results pass through a
// single output register.
// When the receiver stalls, the back end holds its scan on a list hit that meets a
// held one, and the front keeps accepting until its queue is full.
// Reset clears the entry count, total and complete flag; no memory sweep is needed
// because only entries below the count are ever read.
module named_parameter_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] name_low,
	input  logic [55:0] name_high,
	input  logic [31:0] value_bits,
	input  logic [7:0]  param_type,
	input  logic [15:0] param_index,
	input  logic [15:0] total_count,
	input  logic [63:0] filter_low,
	input  logic [55:0] filter_high,
	input  logic [6:0]  max_out,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] out_name_low,
	output logic [55:0] out_name_high,
	output logic [31:0] out_value_bits,
	output logic [7:0]  out_type,
	output logic [15:0] out_index,
	output logic [6:0]  entry_count,
	output logic [15:0] expected_total,
	output logic        complete,
	output logic        last
);
	import npt_pkg::*;

	npt_item_t cmd;
	logic      cmd_valid;
	logic      cmd_ready;

	npt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.name_low    (name_low),
		.name_high   (name_high),
		.value_bits  (value_bits),
		.param_type  (param_type),
		.param_index (param_index),
		.total_count (total_count),
		.filter_low  (filter_low),
		.filter_high (filter_high),
		.max_out     (max_out),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	npt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_name_low   (out_name_low),
		.out_name_high  (out_name_high),
		.out_value_bits (out_value_bits),
		.out_type       (out_type),
		.out_index      (out_index),
		.entry_count    (entry_count),
		.expected_total (expected_total),
		.complete       (complete),
		.last           (last)
	);

	// Only list hits can be followed by more results of the same request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_HIT |-> last)
		else $error("non-hit result without last");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_DROPPED |-> entry_count == 7'(MAX_ENTRIES))
		else $error("entry dropped while table not full");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_MISS || status == STAT_DROPPED) |->
		out_value_bits == 32'd0 && out_index == 16'd0 && out_name_low == 64'd0)
		else $error("miss result carries entry data");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= 7'(MAX_ENTRIES))
		else $error("entry count beyond table size");

endmodule
